// File: src/tvp_pkg.sv
// ----------------------------------------------------------------------------
// tvp_pkg
// Shared types, constants and helpers for the trapezoid velocity profile core.
// ----------------------------------------------------------------------------
package tvp_pkg;

	localparam int DATA_W        = 32;
	localparam int CFG_W         = 31;
	localparam int CFG_IDX_W     = 3;
	localparam int FUNC_W        = 2;
	localparam int PHASE_W       = 2;
	localparam int CHANNELS_DEF  = 3;
	localparam int FRAC_BITS_DEF = 16;
	localparam int END_MULT      = 7;

	// channel selector codes
	localparam logic [FUNC_W-1:0] FUNC_TURN = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FREE = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

	// channel phases
	localparam logic [PHASE_W-1:0] PH_ACCEL  = 2'd0;
	localparam logic [PHASE_W-1:0] PH_CRUISE = 2'd1;
	localparam logic [PHASE_W-1:0] PH_DECEL  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECEL_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_TRACK = 3'd4;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_TMUL, OP_TWB, OP_SETUP,
		OP_PS, OP_PDIV, OP_PDIVW, OP_PM1, OP_PW1, OP_PM2, OP_PW2, OP_PM3, OP_PW3,
		OP_ACC, OP_CRUISE, OP_DDIV, OP_DDIVW, OP_DMUL, OP_DWB, OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHK, ST_TMUL, ST_TWB, ST_SETUP, ST_DISP,
		ST_PS, ST_PDIV, ST_PDIVW, ST_PM1, ST_PW1, ST_PM2, ST_PW2, ST_PM3, ST_PW3,
		ST_ACC, ST_CRUISE, ST_DDIV, ST_DDIVW, ST_DMUL, ST_DWB, ST_FIN
	} state_t;

	typedef struct packed {
		op_t  op;
		logic second;   // second brake prediction of the accelerate pass
	} cmd_t;

	typedef struct packed {
		logic               chan_ok;
		logic               is_turn;
		logic               arrived;
		logic [PHASE_W-1:0] phase;
		logic               ge;
		logic               le;
		logic               div_done;
		logic               accel_ok;
		logic               brake_near;
		logic               out_free;
	} stat_t;

	// clamp to signed 32 bits, returns {clamped, value}
	function automatic logic [DATA_W:0] sat32(input logic signed [71:0] x);
		logic [DATA_W:0] r;
		if (x > 72'sd2147483647)
			r = {1'b1, 32'h7FFF_FFFF};
		else if (x < -72'sd2147483648)
			r = {1'b1, 32'h8000_0000};
		else
			r = {1'b0, x[DATA_W-1:0]};
		return r;
	endfunction

endpackage

// File: src/tvp_div.sv
// ----------------------------------------------------------------------------
// tvp_div
// Unsigned restoring divider, (num << FRAC_BITS) / den, one bit per cycle.
// ----------------------------------------------------------------------------
module tvp_div
	import tvp_pkg::*;
#(
	parameter int NUM_W     = DATA_W,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NUM_W-1:0]           num,
	input  logic [NUM_W-1:0]           den,
	output logic [NUM_W+FRAC_BITS-1:0] quo,
	output logic                       done
);

	localparam int QW    = NUM_W + FRAC_BITS;
	localparam int CNT_W = $clog2(QW + 1);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] rem_q, den_q;
	logic [QW-1:0]    dvd_q;
	logic [NUM_W:0]   trial, diff;
	logic             fits;

	assign trial = {rem_q, dvd_q[QW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};
	assign quo   = dvd_q;
	assign done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= {num, {FRAC_BITS{1'b0}}};
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
			dvd_q <= {dvd_q[QW-2:0], fits};
		end
	end

endmodule

// File: src/tvp_dp.sv
// ----------------------------------------------------------------------------
// tvp_dp
// Datapath: registers, per-channel state, shared multiplier and divider.
// ----------------------------------------------------------------------------
module tvp_dp
	import tvp_pkg::*;
#(
	parameter int CHANNELS  = CHANNELS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output stat_t                stat,
	input  logic [63:0]          in_tdata,
	input  logic [FUNC_W-1:0]    in_tuser,
	input  logic                 in_tlast,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 out_tready,
	output logic                 out_tvalid,
	output logic [DATA_W-1:0]    out_tdata,
	output logic [2:0]           out_tuser
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int QW   = DATA_W + FRAC_BITS;
	localparam logic [CFG_W-1:0]         ONE_Q = CFG_W'(2 ** FRAC_BITS);
	localparam logic signed [DATA_W:0]   END_Q = (DATA_W + 1)'(END_MULT * (2 ** FRAC_BITS));

	// configuration
	logic [CFG_W-1:0] min_q, max_q, dec_q, acc_q, half_q;

	// per-channel state
	logic [PHASE_W-1:0]       ph_q  [CHANNELS];
	logic signed [DATA_W-1:0] bd_q  [CHANNELS];
	logic signed [DATA_W-1:0] pbd_q [CHANNELS];
	logic signed [DATA_W-1:0] ss_q  [CHANNELS];
	logic signed [DATA_W-1:0] sd_q  [CHANNELS];

	// working registers
	logic [FUNC_W-1:0]        func_q;
	logic                     arr_q, dpos_q, dneg_q, sat_q;
	logic signed [DATA_W-1:0] v_q, d_q, vmin_q, s_q, var_q, t1_q, t2_q, inner_q;
	logic [DATA_W-1:0]        ad_q;
	logic signed [63:0]       prod_q;
	logic                     dneg_num_q, dnz_q, dzero_q;
	logic                     ov_q;
	logic [DATA_W-1:0]        od_q;
	logic [2:0]               ou_q;

	logic                     chan_ok;
	logic [CH_W-1:0]          chan;
	logic [PHASE_W-1:0]       cur_ph;
	logic signed [DATA_W-1:0] cur_bd, cur_pbd, cur_ss, cur_sd;
	logic [CFG_W-1:0]         vmin_abs;
	logic signed [DATA_W:0]   acc_x, dec_x, dir_acc, dir_dec, dir_end, v_ext, bd_ext, ad_s;
	logic [DATA_W:0]          v_abs;
	logic                     v_lt_max, accel_ok, brake_near;
	logic                     d_pos, d_neg, reversal;

	// multiplier
	logic signed [DATA_W-1:0] mul_a, mul_b;
	logic signed [63:0]       prod_sh;
	logic [DATA_W:0]          qm;

	// brake prediction
	logic signed [33:0]       bump;
	logic [DATA_W:0]          b1, b2;
	logic signed [DATA_W-1:0] b1v;
	logic signed [DATA_W:0]   b1x, babs;
	logic signed [DATA_W:0]   pnum;
	logic [DATA_W-1:0]        pmag, sd_abs;
	logic signed [33:0]       w3_sum, acc_sum;
	logic [DATA_W:0]          w3r, accr;

	// deceleration
	logic signed [35:0]       inner_sum, dwb_sum;
	logic [DATA_W:0]          inner_r, dwb_r;

	// divider
	logic                     div_start, div_done;
	logic [DATA_W-1:0]        div_num, div_den;
	logic [QW-1:0]            div_quo;
	logic [DATA_W:0]          dr;

	assign chan_ok  = (func_q != FUNC_NONE) && (int'(func_q) < CHANNELS);
	assign chan     = CH_W'(func_q);
	assign cur_ph   = ph_q[chan];
	assign cur_bd   = bd_q[chan];
	assign cur_pbd  = pbd_q[chan];
	assign cur_ss   = ss_q[chan];
	assign cur_sd   = sd_q[chan];

	assign vmin_abs = (dpos_q | dneg_q) ? min_q : '0;
	assign acc_x    = $signed({2'b00, acc_q});
	assign dec_x    = $signed({2'b00, dec_q});
	assign dir_acc  = dpos_q ? acc_x : (dneg_q ? -acc_x : '0);
	assign dir_dec  = dpos_q ? dec_x : (dneg_q ? -dec_x : '0);
	assign dir_end  = dpos_q ? END_Q : (dneg_q ? -END_Q : '0);

	assign v_ext      = (DATA_W + 1)'(v_q);
	assign v_abs      = v_q[DATA_W-1] ? unsigned'(-v_ext) : unsigned'(v_ext);
	assign v_lt_max   = v_abs < {2'b00, max_q};
	assign bd_ext     = (DATA_W + 1)'(cur_bd);
	assign ad_s       = $signed({1'b0, ad_q});
	assign accel_ok   = (ad_s >= bd_ext) && v_lt_max;
	assign brake_near = ad_s < bd_ext;

	assign d_pos    = d_q > 0;
	assign d_neg    = d_q < 0;
	assign reversal = (d_pos && v_q < 0) || (d_neg && v_q > 0);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_TMUL: begin
				mul_a = d_q;
				mul_b = $signed({1'b0, half_q});
			end
			OP_PM1: begin
				mul_a = s_q;
				mul_b = var_q;
			end
			OP_PM2: begin
				mul_a = $signed({2'b00, dec_q[CFG_W-1:1]});
				mul_b = var_q;
			end
			OP_PM3: begin
				mul_a = t2_q;
				mul_b = var_q;
			end
			OP_DMUL: begin
				mul_a = var_q;
				mul_b = inner_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// floor shift then clamp
	assign prod_sh = prod_q >>> FRAC_BITS;
	assign qm      = sat32(72'(prod_sh));

	// predicted speed magnitude
	assign bump = 34'(v_q) + 34'(cmd.second ? dir_acc : acc_x);
	assign b1   = sat32(72'(bump));
	assign b1v  = b1[DATA_W-1:0];
	assign b1x  = (DATA_W + 1)'(b1v);
	assign babs = b1v[DATA_W-1] ? -b1x : b1x;
	assign b2   = sat32(72'(babs));

	assign pnum    = (DATA_W + 1)'(s_q) - $signed({2'b00, vmin_abs});
	assign pmag    = pnum[DATA_W] ? DATA_W'(unsigned'(-pnum)) : DATA_W'(unsigned'(pnum));
	assign sd_abs  = cur_sd[DATA_W-1] ? unsigned'(-cur_sd) : unsigned'(cur_sd);

	assign w3_sum  = 34'(t1_q) - 34'($signed(qm[DATA_W-1:0]));
	assign w3r     = sat32(72'(w3_sum));
	assign acc_sum = 34'(v_q) + 34'(dir_acc);
	assign accr    = sat32(72'(acc_sum));

	assign inner_sum = 36'(cur_ss) - 36'(dir_dec) - 36'(dir_end) - 36'(vmin_q);
	assign inner_r   = sat32(72'(inner_sum));
	assign dwb_sum   = 36'($signed(qm[DATA_W-1:0])) + 36'(dir_end) + 36'(vmin_q);
	assign dwb_r     = sat32(72'(dwb_sum));

	assign div_start = (cmd.op == OP_PDIV) || (cmd.op == OP_DDIV);
	assign div_num   = (cmd.op == OP_DDIV) ? ad_q : pmag;
	assign div_den   = (cmd.op == OP_DDIV) ? sd_abs : {1'b0, dec_q};

	tvp_div #(
		.NUM_W     (DATA_W),
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.done   (div_done)
	);

	// signed, clamped quotient; zero divisor goes to the end of the numerator sign, or to zero for a zero numerator
	always_comb begin
		if (dzero_q)
			dr = {1'b1, dneg_num_q ? 32'h8000_0000 : (dnz_q ? 32'h0 : 32'h7FFF_FFFF)};
		else if (!dneg_num_q)
			dr = (|div_quo[QW-1:DATA_W-1]) ? {1'b1, 32'h7FFF_FFFF}
			                                : {1'b0, div_quo[DATA_W-1:0]};
		else if ((|div_quo[QW-1:DATA_W]) || (div_quo[DATA_W-1] && |div_quo[DATA_W-2:0]))
			dr = {1'b1, 32'h8000_0000};
		else
			dr = {1'b0, DATA_W'(-div_quo[DATA_W-1:0])};
	end

	always_comb begin
		stat.chan_ok    = chan_ok;
		stat.is_turn    = func_q == FUNC_TURN;
		stat.arrived    = arr_q;
		stat.phase      = chan_ok ? cur_ph : PH_ACCEL;
		stat.ge         = v_q >= vmin_q;
		stat.le         = v_q <= vmin_q;
		stat.div_done   = div_done;
		stat.accel_ok   = accel_ok;
		stat.brake_near = brake_near;
		stat.out_free   = !ov_q || out_tready;
	end

	// configuration, channel state, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= '0;
			max_q  <= '0;
			dec_q  <= ONE_Q;
			acc_q  <= '0;
			half_q <= ONE_Q;
			ov_q   <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				ph_q[i]  <= PH_ACCEL;
				bd_q[i]  <= '0;
				pbd_q[i] <= '0;
				ss_q[i]  <= '0;
				sd_q[i]  <= '0;
			end
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					CFG_MIN_SPEED:  min_q  <= cfg_wdata;
					CFG_MAX_SPEED:  max_q  <= cfg_wdata;
					CFG_DECEL_STEP: dec_q  <= cfg_wdata;
					CFG_ACCEL_STEP: acc_q  <= cfg_wdata;
					CFG_HALF_TRACK: half_q <= cfg_wdata;
					default: ;
				endcase
			end

			unique case (cmd.op)
				OP_SETUP: begin
					if (arr_q) begin
						ph_q[chan]  <= PH_ACCEL;
						bd_q[chan]  <= '0;
						pbd_q[chan] <= '0;
						ss_q[chan]  <= '0;
						sd_q[chan]  <= '0;
					end else if (reversal) begin
						ph_q[chan] <= PH_ACCEL;
					end
				end
				OP_PW3: begin
					pbd_q[chan] <= cur_bd;
					bd_q[chan]  <= w3r[DATA_W-1:0];
				end
				OP_ACC: begin
					if (!accel_ok) begin
						ph_q[chan] <= PH_CRUISE;
						if (v_lt_max)
							bd_q[chan] <= cur_pbd;
					end
				end
				OP_CRUISE: begin
					if (brake_near) begin
						ph_q[chan] <= PH_DECEL;
						sd_q[chan] <= d_q;
						ss_q[chan] <= v_q;
					end else begin
						ph_q[chan] <= PH_ACCEL;
					end
				end
				OP_DWB: ph_q[chan] <= PH_ACCEL;
				default: ;
			endcase

			if (cmd.op == OP_OUT)
				ov_q <= 1'b1;
			else if (out_tready)
				ov_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (cmd.op)
			OP_LOAD: begin
				func_q <= in_tuser;
				arr_q  <= in_tlast;
				v_q    <= in_tdata[31:0];
				d_q    <= in_tdata[63:32];
				sat_q  <= 1'b0;
			end
			OP_TWB: begin
				d_q   <= qm[DATA_W-1:0];
				sat_q <= sat_q | qm[DATA_W];
			end
			OP_SETUP: begin
				if (arr_q) begin
					v_q <= (func_q == FUNC_FREE) ? $signed({1'b0, min_q}) : '0;
				end else begin
					dpos_q <= d_pos;
					dneg_q <= d_neg;
					if (reversal)
						v_q <= '0;
					vmin_q <= d_pos ? $signed({1'b0, min_q})
					        : (d_neg ? -$signed({1'b0, min_q}) : '0);
					ad_q   <= d_q[DATA_W-1] ? unsigned'(-d_q) : unsigned'(d_q);
				end
			end
			OP_PS: begin
				s_q   <= b2[DATA_W-1:0];
				sat_q <= sat_q | b1[DATA_W] | b2[DATA_W];
			end
			OP_PDIV: begin
				dneg_num_q <= pnum[DATA_W];
				dnz_q      <= pnum == 0;
				dzero_q    <= dec_q == '0;
			end
			OP_DDIV: begin
				dneg_num_q <= 1'b0;
				dnz_q      <= ad_q == '0;
				dzero_q    <= cur_sd == '0;
				inner_q    <= inner_r[DATA_W-1:0];
				sat_q      <= sat_q | inner_r[DATA_W];
			end
			OP_PDIVW, OP_DDIVW: begin
				if (div_done) begin
					var_q <= dr[DATA_W-1:0];
					sat_q <= sat_q | dr[DATA_W];
				end
			end
			OP_PW1: begin
				t1_q  <= qm[DATA_W-1:0];
				sat_q <= sat_q | qm[DATA_W];
			end
			OP_PW2: begin
				t2_q  <= qm[DATA_W-1:0];
				sat_q <= sat_q | qm[DATA_W];
			end
			OP_PW3: sat_q <= sat_q | qm[DATA_W] | w3r[DATA_W];
			OP_ACC: begin
				if (accel_ok) begin
					v_q   <= accr[DATA_W-1:0];
					sat_q <= sat_q | accr[DATA_W];
				end
			end
			OP_CRUISE: begin
				if (brake_near && v_abs < {2'b00, vmin_abs})
					v_q <= vmin_q;
			end
			OP_DWB: begin
				v_q   <= dwb_r[DATA_W-1:0];
				sat_q <= sat_q | qm[DATA_W] | dwb_r[DATA_W];
			end
			OP_OUT: begin
				od_q <= chan_ok ? unsigned'(v_q) : '0;
				ou_q <= chan_ok ? {sat_q, cur_ph} : '0;
			end
			default: ;
		endcase
	end

	assign out_tvalid = ov_q;
	assign out_tdata  = od_q;
	assign out_tuser  = ou_q;

endmodule

// File: src/tvp_ctrl.sv
// ----------------------------------------------------------------------------
// tvp_ctrl
// Sequencer: walks one item through the phase passes of its channel.
// ----------------------------------------------------------------------------
module tvp_ctrl
	import tvp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic   second_q, second_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		second_d   = second_q;
		in_ready   = 1'b0;
		cmd.op     = OP_NONE;
		cmd.second = second_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (!stat.chan_ok)
					state_d = ST_FIN;
				else if (stat.is_turn)
					state_d = ST_TMUL;
				else
					state_d = ST_SETUP;
			end
			ST_TMUL: begin
				cmd.op  = OP_TMUL;
				state_d = ST_TWB;
			end
			ST_TWB: begin
				cmd.op  = OP_TWB;
				state_d = ST_SETUP;
			end
			ST_SETUP: begin
				cmd.op  = OP_SETUP;
				state_d = stat.arrived ? ST_FIN : ST_DISP;
			end
			ST_DISP: begin
				unique case (stat.phase)
					PH_ACCEL: begin
						second_d = !stat.ge;
						state_d  = ST_PS;
					end
					PH_CRUISE: state_d = ST_CRUISE;
					PH_DECEL:  state_d = ST_DDIV;
					default:   state_d = ST_FIN;
				endcase
			end
			ST_PS: begin
				cmd.op  = OP_PS;
				state_d = ST_PDIV;
			end
			ST_PDIV: begin
				cmd.op  = OP_PDIV;
				state_d = ST_PDIVW;
			end
			ST_PDIVW: begin
				cmd.op = OP_PDIVW;
				if (stat.div_done)
					state_d = ST_PM1;
			end
			ST_PM1: begin
				cmd.op  = OP_PM1;
				state_d = ST_PW1;
			end
			ST_PW1: begin
				cmd.op  = OP_PW1;
				state_d = ST_PM2;
			end
			ST_PM2: begin
				cmd.op  = OP_PM2;
				state_d = ST_PW2;
			end
			ST_PW2: begin
				cmd.op  = OP_PW2;
				state_d = ST_PM3;
			end
			ST_PM3: begin
				cmd.op  = OP_PM3;
				state_d = ST_PW3;
			end
			ST_PW3: begin
				cmd.op = OP_PW3;
				if (!second_q && stat.le) begin
					second_d = 1'b1;
					state_d  = ST_PS;
				end else begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.op  = OP_ACC;
				state_d = stat.accel_ok ? ST_FIN : ST_DISP;
			end
			ST_CRUISE: begin
				cmd.op  = OP_CRUISE;
				state_d = stat.brake_near ? ST_DISP : ST_FIN;
			end
			ST_DDIV: begin
				cmd.op  = OP_DDIV;
				state_d = ST_DDIVW;
			end
			ST_DDIVW: begin
				cmd.op = OP_DDIVW;
				if (stat.div_done)
					state_d = ST_DMUL;
			end
			ST_DMUL: begin
				cmd.op  = OP_DMUL;
				state_d = ST_DWB;
			end
			ST_DWB: begin
				cmd.op  = OP_DWB;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.op  = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: src/trapezoid_velocity_profile_core.sv
// ----------------------------------------------------------------------------
// trapezoid_velocity_profile_core
// Per-channel trapezoidal speed profile in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream: tdata = {remaining_distance, current_speed}, tuser = func,
//    tlast = arrived. One transfer is one control step of one channel.
//  - Output stream: one transfer per input, tdata = speed_command,
//    tuser = {saturated, phase}.
//  - Config: cfg_wen/cfg_index/cfg_wdata, written while the core is idle.
//  - One item at a time. An unused channel goes straight to the output,
//    an arrival ends after the setup pass, and the longest path is a turn
//    step that runs two brake predictions and a deceleration pass. The
//    shared bit-serial divider dominates; each product is registered on
//    the single 32x32 multiplier before it is written back.
//  - The result sits in an output register; the next input is taken while
//    it waits. A stalled receiver holds the core in its final state until
//    the output register frees up.
//  - Reset: all channels back to accelerate phase, state cleared,
//    registers to their defaults (decel step and half track = 1.0).
// ----------------------------------------------------------------------------
module trapezoid_velocity_profile_core
	import tvp_pkg::*;
#(
	parameter int CHANNELS  = CHANNELS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [63:0]          s_axis_tdata,   // [31:0] current_speed, [63:32] remaining_distance
	input  logic [FUNC_W-1:0]    s_axis_tuser,   // [1:0] func
	input  logic                 s_axis_tlast,   // arrived
	// output stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [DATA_W-1:0]    m_axis_tdata,   // [31:0] speed_command
	output logic [2:0]           m_axis_tuser,   // [1:0] phase, [2] saturated
	// register writes
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer: decides the order of passes from datapath status
	tvp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: channel state, multiplier, divider, output register
	tvp_dp #(
		.CHANNELS  (CHANNELS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_tdata   (s_axis_tdata),
		.in_tuser   (s_axis_tuser),
		.in_tlast   (s_axis_tlast),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.out_tready (m_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.out_tdata  (m_axis_tdata),
		.out_tuser  (m_axis_tuser)
	);

endmodule
